### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the controller port rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CPIO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CPIO_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `CPIO_ASSERT(label, clk, rst, !(cond), msg)

`endif

### rtl/cpio_pkg.sv
// ----------------------------------------------------------------------------
// cpio_pkg
// shared types, codes and constants of the controller port register block
// ----------------------------------------------------------------------------
`default_nettype none

package cpio_pkg;

   // item kinds carried in req_tuser
   localparam logic [2:0] MODE_READ      = 3'd0;
   localparam logic [2:0] MODE_WRITE     = 3'd1;
   localparam logic [2:0] MODE_PAD_BTN   = 3'd2;
   localparam logic [2:0] MODE_MOUSE_BTN = 3'd3;
   localparam logic [2:0] MODE_MOTION    = 3'd4;

   // bus register offsets, bit 0 cleared
   localparam logic [11:0] ADDR_TEMP    = 12'h000;
   localparam logic [11:0] ADDR_PORT0   = 12'h010;
   localparam logic [11:0] ADDR_PORT1   = 12'h012;
   localparam logic [11:0] ADDR_PORT2   = 12'h014;
   localparam logic [11:0] ADDR_SENSOR  = 12'h030;
   localparam logic [11:0] ADDR_MOUSE_X = 12'h050;
   localparam logic [11:0] ADDR_MOUSE_Y = 12'h052;

   // configuration register indexes
   localparam logic [2:0] CSR_SCAN_PAD   = 3'd0;
   localparam logic [2:0] CSR_SCAN_MOUSE = 3'd1;
   localparam logic [2:0] CSR_PAD_PLUG   = 3'd2;
   localparam logic [2:0] CSR_MOUSE_PLUG = 3'd3;
   localparam logic [2:0] CSR_TEMP       = 3'd4;
   localparam logic [2:0] CSR_SENSOR     = 3'd5;

   localparam logic [9:0] TEMP_RESET   = 10'd352;
   localparam logic [6:0] SENSOR_RESET = 7'd25;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic       scan_pad_enable;
      logic       scan_mouse_enable;
      logic       pad_plugged;
      logic       mouse_plugged;
      logic [9:0] temp_code;
      logic [6:0] sensor_bits;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [11:0]        addr;
      logic [15:0]        write_data;
      logic [15:0]        button_mask;
      logic               pressed;
      logic signed [12:0] delta_x;
      logic signed [12:0] delta_y;
   } item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        unmapped;
   } result_type;

endpackage

`default_nettype wire

### rtl/cpio_csr.sv
// ----------------------------------------------------------------------------
// cpio_csr
// apb configuration registers of the controller port block
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cpio_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cpio_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cpio_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output cpio_pkg::cfg_type                    cfg
);

   cpio_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            cpio_pkg::CSR_SCAN_PAD:   cfg_in.scan_pad_enable   = csr_pwdata[0];
            cpio_pkg::CSR_SCAN_MOUSE: cfg_in.scan_mouse_enable = csr_pwdata[0];
            cpio_pkg::CSR_PAD_PLUG:   cfg_in.pad_plugged       = csr_pwdata[0];
            cpio_pkg::CSR_MOUSE_PLUG: cfg_in.mouse_plugged     = csr_pwdata[0];
            cpio_pkg::CSR_TEMP:       cfg_in.temp_code         = csr_pwdata[9:0];
            cpio_pkg::CSR_SENSOR:     cfg_in.sensor_bits       = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         cpio_pkg::CSR_SCAN_PAD:   csr_prdata = {31'b0, cfg_ff.scan_pad_enable};
         cpio_pkg::CSR_SCAN_MOUSE: csr_prdata = {31'b0, cfg_ff.scan_mouse_enable};
         cpio_pkg::CSR_PAD_PLUG:   csr_prdata = {31'b0, cfg_ff.pad_plugged};
         cpio_pkg::CSR_MOUSE_PLUG: csr_prdata = {31'b0, cfg_ff.mouse_plugged};
         cpio_pkg::CSR_TEMP:       csr_prdata = {22'b0, cfg_ff.temp_code};
         cpio_pkg::CSR_SENSOR:     csr_prdata = {25'b0, cfg_ff.sensor_bits};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_pad_enable   <= 1'b0;
         cfg_ff.scan_mouse_enable <= 1'b0;
         cfg_ff.pad_plugged       <= 1'b0;
         cfg_ff.mouse_plugged     <= 1'b0;
         cfg_ff.temp_code         <= cpio_pkg::TEMP_RESET;
         cfg_ff.sensor_bits       <= cpio_pkg::SENSOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cpio_core.sv
// ----------------------------------------------------------------------------
// cpio_core
// port state, register decode and event handling, one item per cycle unless fire is held low
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cpio_pkg::cfg_type    cfg,
   input  wire cpio_pkg::item_type   item,
   input  wire logic                 fire,
   output cpio_pkg::result_type      result
);

   logic [15:0] pad_btn_ff,  pad_btn_in;
   logic [2:0]  mouse_btn_ff, mouse_btn_in;
   logic [11:0] cnt_x_ff,    cnt_x_in;
   logic [11:0] cnt_y_ff,    cnt_y_in;
   logic        latch_ff,    latch_in;

   logic        pad_present, pad_sel, mouse_cnt;
   logic [11:0] addr_even;
   logic [15:0] mouse_word;
   logic [2:0]  mouse_mask;
   logic [13:0] sum_x, sum_y;

   // clamp a 14-bit signed sum to the 12-bit counter range
   function automatic logic [11:0] sat12(input logic [13:0] s);
      logic [11:0] r;
      if (s[13:11] == 3'b000 || s[13:11] == 3'b111) r = s[11:0];
      else if (s[13])                               r = 12'h800;
      else                                          r = 12'h7FF;
      return r;
   endfunction

   assign pad_present = cfg.pad_plugged & ~cfg.mouse_plugged;
   assign pad_sel     = cfg.scan_pad_enable & pad_present;
   assign mouse_cnt   = cfg.scan_mouse_enable & cfg.mouse_plugged;
   assign addr_even   = {item.addr[11:1], 1'b0};
   assign mouse_word  = {1'b1, ~mouse_btn_ff, 4'b0, 1'b1, ~mouse_btn_ff, 4'b0};
   assign mouse_mask  = item.button_mask[14:12];
   assign sum_x       = {{2{cnt_x_ff[11]}}, cnt_x_ff} + {item.delta_x[12], item.delta_x};
   assign sum_y       = {{2{cnt_y_ff[11]}}, cnt_y_ff} + {item.delta_y[12], item.delta_y};

   always_comb begin
      pad_btn_in       = pad_btn_ff;
      mouse_btn_in     = mouse_btn_ff;
      cnt_x_in         = cnt_x_ff;
      cnt_y_in         = cnt_y_ff;
      latch_in         = latch_ff;
      result.read_data = '0;
      result.unmapped  = 1'b0;
      unique case (item.mode)
         cpio_pkg::MODE_READ: begin
            unique case (addr_even)
               cpio_pkg::ADDR_TEMP: result.read_data = {cfg.temp_code, 6'b0};
               cpio_pkg::ADDR_PORT0: begin
                  if (pad_sel) begin
                     result.read_data = {4'b0, pad_btn_ff[7:4], 4'b0, pad_btn_ff[3:1], 1'b1};
                  end else if (cfg.mouse_plugged) begin
                     result.read_data = mouse_word;
                  end
               end
               cpio_pkg::ADDR_PORT1: begin
                  if (pad_sel) begin
                     result.read_data = {12'b0, pad_btn_ff[11:8]};
                  end else if (cfg.mouse_plugged) begin
                     result.read_data = mouse_word;
                  end
               end
               cpio_pkg::ADDR_PORT2: begin
                  if (!pad_sel && cfg.mouse_plugged) begin
                     result.read_data = mouse_word;
                  end
               end
               cpio_pkg::ADDR_SENSOR: begin
                  result.read_data = {7'b0, latch_ff, 1'b0, cfg.sensor_bits};
               end
               cpio_pkg::ADDR_MOUSE_X: begin
                  if (mouse_cnt) begin
                     result.read_data = {1'b0, ~mouse_btn_ff, cnt_x_ff};
                     if (fire) cnt_x_in = '0;
                  end
               end
               cpio_pkg::ADDR_MOUSE_Y: begin
                  if (mouse_cnt) begin
                     result.read_data = {4'b0, cnt_y_ff};
                     if (fire) cnt_y_in = '0;
                  end
               end
               default: result.unmapped = 1'b1;
            endcase
         end
         cpio_pkg::MODE_WRITE: begin
            if (addr_even == cpio_pkg::ADDR_SENSOR) begin
               if (fire) latch_in = item.write_data[8];
            end else begin
               result.unmapped = 1'b1;
            end
         end
         cpio_pkg::MODE_PAD_BTN: begin
            if (fire && pad_present) begin
               pad_btn_in = item.pressed ? (pad_btn_ff | item.button_mask)
                                         : (pad_btn_ff & ~item.button_mask);
            end
         end
         cpio_pkg::MODE_MOUSE_BTN: begin
            if (fire && cfg.mouse_plugged) begin
               mouse_btn_in = item.pressed ? (mouse_btn_ff | mouse_mask)
                                           : (mouse_btn_ff & ~mouse_mask);
            end
         end
         cpio_pkg::MODE_MOTION: begin
            if (fire && cfg.mouse_plugged) begin
               cnt_x_in = sat12(sum_x);
               cnt_y_in = sat12(sum_y);
            end
         end
         default: ;
      endcase
      // unplugged mouse keeps its counters at zero
      if (!cfg.mouse_plugged) begin
         cnt_x_in = '0;
         cnt_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_btn_ff   <= '0;
         mouse_btn_ff <= '0;
         cnt_x_ff     <= '0;
         cnt_y_ff     <= '0;
         latch_ff     <= 1'b0;
      end else begin
         pad_btn_ff   <= pad_btn_in;
         mouse_btn_ff <= mouse_btn_in;
         cnt_x_ff     <= cnt_x_in;
         cnt_y_ff     <= cnt_y_in;
         latch_ff     <= latch_in;
      end
   end

endmodule

`default_nettype wire

### rtl/controller_port_io_registers.sv
// ----------------------------------------------------------------------------
// controller_port_io_registers
// game pad / mouse input port seen through 16-bit registers, stream front end
// ----------------------------------------------------------------------------
// Each request beat is one bus read, bus write, pad button change, mouse
// button change or mouse motion, and produces exactly one response beat
// carrying the read word (zero for anything but a read) and an unmapped flag
// for bus accesses that miss the register map. The block takes one beat
// every clock cycle while the response side does not stall; a beat is held
// in the input register and leaves through the result register, from which
// the response beat is offered. The rate is set by the update of the port
// state (buttons, saturating mouse counters, sensor latch) in the core.
// Configuration must be written by the user through the apb port only while
// no beat is in flight; the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module controller_port_io_registers (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // addr[11:0], write_data[27:12], button_mask[43:28], pressed[44],
   // delta_x[57:45], delta_y[70:58], zero pad[71]
   input  wire logic [cpio_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  wire logic [cpio_pkg::REQ_USER_W-1:0] req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // read_data[15:0]
   output logic      [cpio_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // unmapped[0]
   output logic      [cpio_pkg::RSP_USER_W-1:0] rsp_tuser,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cpio_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cpio_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cpio_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   cpio_pkg::cfg_type    cfg;
   cpio_pkg::item_type   s1_item_ff, s1_item_in;
   cpio_pkg::result_type result;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff;
   logic                 rsp_unmapped_ff;
   logic                 req_accept;
   logic                 s1_advance;

   // configuration registers
   cpio_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the beat in the input register moves on when the result register is
   // free or is being emptied in the same cycle
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_advance;
   assign req_accept = req_tvalid & req_tready;

   // unpack request fields
   always_comb begin
      s1_item_in.mode        = req_tuser[2:0];
      s1_item_in.addr        = req_tdata[11:0];
      s1_item_in.write_data  = req_tdata[27:12];
      s1_item_in.button_mask = req_tdata[43:28];
      s1_item_in.pressed     = req_tdata[44];
      s1_item_in.delta_x     = req_tdata[57:45];
      s1_item_in.delta_y     = req_tdata[70:58];
   end

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & ~rsp_tready);

   // decode and state update, committed only when the beat advances
   cpio_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (s1_item_ff),
      .fire   (s1_advance),
      .result (result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_advance) begin
         rsp_data_ff     <= result.read_data;
         rsp_unmapped_ff <= result.unmapped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_unmapped_ff;

   // a response only appears after a beat sat in the input register
   `CPIO_ASSERT_NEVER(a_rsp_from_s1, clock, reset, $rose(rsp_valid_ff) && !$past(s1_valid_ff), "response without input beat")

   // a stalled input beat is not lost
   `CPIO_ASSERT(a_s1_holds, clock, reset, s1_valid_ff && !s1_advance |=> s1_valid_ff, "input beat dropped")

   // only bus accesses can be flagged unmapped
   `CPIO_ASSERT(a_unmapped_bus, clock, reset, s1_advance && s1_item_ff.mode != cpio_pkg::MODE_READ && s1_item_ff.mode != cpio_pkg::MODE_WRITE |=> !rsp_unmapped_ff, "unmapped on event")

   // non-read beats return a zero word
   `CPIO_ASSERT(a_zero_data, clock, reset, s1_advance && s1_item_ff.mode != cpio_pkg::MODE_READ |=> rsp_data_ff == 16'h0000, "data on non-read")

endmodule

`default_nettype wire

### tb/sv/port_response_checker.sv
// ----------------------------------------------------------------------------
// port_response_checker
// watches the request, response and apb channels of the controller port block
// ----------------------------------------------------------------------------
// Keeps its own copy of the port state and configuration. Every accepted
// request beat is run through the predictor and its response is queued.
// Every accepted response beat is compared field by field with the oldest
// queued one. Failures are counted and handed to the testbench top.

module port_response_checker
   import cpio_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [REQ_USER_W-1:0]   req_tuser,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [RSP_USER_W-1:0]   rsp_tuser,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic                    csr_pready,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type            cfg;
   logic        [15:0] pad_buttons;
   logic        [2:0]  mouse_buttons;
   logic signed [11:0] count_x;
   logic signed [11:0] count_y;
   logic               sensor_latch;
   result_type         pending_responses[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic logic signed [11:0] clamp_count(logic signed [11:0] cur,
                                                      logic signed [12:0] delta);
      logic signed [13:0] sum;
      sum = cur + delta;
      if (sum < -14'sd2048) return -12'sd2048;
      if (sum > 14'sd2047) return 12'sd2047;
      return sum[11:0];
   endfunction

   // applies one beat to the port state and returns its response
   function automatic result_type step_port(item_type it);
      result_type       res;
      logic [11:0]      offset;
      logic             pad_on;
      logic             pad_sel;
      logic             mouse_cnt;
      logic [2:0]       mouse_bits;
      res        = '0;
      offset     = {it.addr[11:1], 1'b0};
      pad_on     = cfg.pad_plugged && !cfg.mouse_plugged;
      pad_sel    = cfg.scan_pad_enable && pad_on;
      mouse_cnt  = cfg.scan_mouse_enable && cfg.mouse_plugged;
      mouse_bits = it.button_mask[14:12];
      case (it.mode)
         MODE_READ: begin
            case (offset)
               ADDR_TEMP: res.read_data = {cfg.temp_code, 6'b0};
               ADDR_PORT0, ADDR_PORT1, ADDR_PORT2: begin
                  if (pad_sel) begin
                     if (offset == ADDR_PORT0)
                        res.read_data = {4'h0, pad_buttons[7:4], 4'h0, pad_buttons[3:1], 1'b1};
                     else if (offset == ADDR_PORT1)
                        res.read_data = {12'h0, pad_buttons[11:8]};
                  end else if (cfg.mouse_plugged) begin
                     res.read_data = {1'b1, ~mouse_buttons, 4'h0, 1'b1, ~mouse_buttons, 4'h0};
                  end
               end
               ADDR_SENSOR: res.read_data = {7'h0, sensor_latch, 1'b0, cfg.sensor_bits};
               ADDR_MOUSE_X: begin
                  if (mouse_cnt) begin
                     res.read_data = {1'b0, ~mouse_buttons, count_x};
                     count_x = '0;
                  end
               end
               ADDR_MOUSE_Y: begin
                  if (mouse_cnt) begin
                     res.read_data = {4'h0, count_y};
                     count_y = '0;
                  end
               end
               default: res.unmapped = 1'b1;
            endcase
         end
         MODE_WRITE: begin
            if (offset == ADDR_SENSOR) sensor_latch = it.write_data[8];
            else res.unmapped = 1'b1;
         end
         MODE_PAD_BTN: begin
            if (pad_on) begin
               if (it.pressed) pad_buttons = pad_buttons | it.button_mask;
               else pad_buttons = pad_buttons & ~it.button_mask;
            end
         end
         MODE_MOUSE_BTN: begin
            if (cfg.mouse_plugged) begin
               if (it.pressed) mouse_buttons = mouse_buttons | mouse_bits;
               else mouse_buttons = mouse_buttons & ~mouse_bits;
            end
         end
         MODE_MOTION: begin
            if (cfg.mouse_plugged) begin
               count_x = clamp_count(count_x, it.delta_x);
               count_y = clamp_count(count_y, it.delta_y);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      item_type   beat;
      result_type want;
      if (reset) begin
         cfg.scan_pad_enable   = 1'b0;
         cfg.scan_mouse_enable = 1'b0;
         cfg.pad_plugged       = 1'b0;
         cfg.mouse_plugged     = 1'b0;
         cfg.temp_code         = TEMP_RESET;
         cfg.sensor_bits       = SENSOR_RESET;
         pad_buttons           = '0;
         mouse_buttons         = '0;
         count_x               = '0;
         count_y               = '0;
         sensor_latch          = 1'b0;
         pending_responses.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               CSR_SCAN_PAD:   cfg.scan_pad_enable = csr_pwdata[0];
               CSR_SCAN_MOUSE: cfg.scan_mouse_enable = csr_pwdata[0];
               CSR_PAD_PLUG:   cfg.pad_plugged = csr_pwdata[0];
               CSR_MOUSE_PLUG: begin
                  cfg.mouse_plugged = csr_pwdata[0];
                  if (!csr_pwdata[0]) begin
                     count_x = '0;
                     count_y = '0;
                  end
               end
               CSR_TEMP:       cfg.temp_code = csr_pwdata[9:0];
               CSR_SENSOR:     cfg.sensor_bits = csr_pwdata[6:0];
               default: ;
            endcase
         end
         // response side first, a response never belongs to a beat of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: response with none expected, read_data %h unmapped %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               fail_count++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_tdata !== want.read_data) begin
                  $display("%0t: read_data expected %h got %h", $time, want.read_data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.unmapped) begin
                  $display("%0t: unmapped expected %b got %b", $time, want.unmapped, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beat.mode        = req_tuser[2:0];
            beat.addr        = req_tdata[11:0];
            beat.write_data  = req_tdata[27:12];
            beat.button_mask = req_tdata[43:28];
            beat.pressed     = req_tdata[44];
            beat.delta_x     = req_tdata[57:45];
            beat.delta_y     = req_tdata[70:58];
            pending_responses.push_back(step_port(beat));
         end
      end
      outstanding = pending_responses.size();
   end

endmodule

### tb/sv/tb_controller_port_io_registers.sv
// ----------------------------------------------------------------------------
// tb_controller_port_io_registers
// stream and apb testbench for the controller port register block
// ----------------------------------------------------------------------------
// Drives request beats (bus reads and writes, pad and mouse button changes,
// mouse motion, unknown kinds) with random gaps and random response stalls,
// rewrites the configuration between phases while the block is idle, and
// leaves all checking to the response checker beside the block.

module tb_controller_port_io_registers;
   import cpio_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // register index past the end of the map, writes there must do nothing
   localparam logic [2:0] CSR_UNUSED        = 3'd6;
   // first item kind the block does not know
   localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
   localparam int         RANDOM_PHASES     = 6;
   localparam int         BEATS_PER_PHASE   = 190;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    outstanding;

   // cleared for one whole phase so that both sides run back to back
   bit                    idling_on = 1'b1;

   // 20 ns clock, starts low so the first rising edge is at 10 ns
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   controller_port_io_registers i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   port_response_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // response side stalls with a chance of 7 in a hundred while idling is on, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready = !(idling_on && $urandom_range(99) < 7);
   end

   // one request beat: optional gap, then hold valid until the rising edge takes it
   task automatic send_beat(input item_type it);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 7) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.mode;
      req_tdata  = {1'b0, it.delta_y, it.delta_x, it.pressed, it.button_mask,
                    it.write_data, it.addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and let every response drain before touching the registers
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      // input and result registers drain, leave a little margin
      repeat (3) @(negedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic item_type blank_item(input logic [2:0] mode);
      item_type it;
      it      = '0;
      it.mode = mode;
      return it;
   endfunction

   task automatic bus_read(input logic [11:0] addr);
      item_type it;
      it      = blank_item(MODE_READ);
      it.addr = addr;
      send_beat(it);
   endtask

   task automatic bus_write(input logic [11:0] addr, input logic [15:0] data);
      item_type it;
      it            = blank_item(MODE_WRITE);
      it.addr       = addr;
      it.write_data = data;
      send_beat(it);
   endtask

   task automatic button_event(input logic [2:0] mode, input logic [15:0] mask,
                               input logic pressed);
      item_type it;
      it             = blank_item(mode);
      it.button_mask = mask;
      it.pressed     = pressed;
      send_beat(it);
   endtask

   task automatic motion(input logic signed [12:0] dx, input logic signed [12:0] dy);
      item_type it;
      it         = blank_item(MODE_MOTION);
      it.delta_x = dx;
      it.delta_y = dy;
      send_beat(it);
   endtask

   function automatic logic signed [12:0] random_delta();
      // mostly small steps so counters wander, sometimes the full range
      if ($urandom_range(3) == 0) return 13'($urandom);
      return 13'(int'($urandom_range(400)) - 200);
   endfunction

   function automatic logic [11:0] mapped_offset();
      logic [11:0] base;
      case ($urandom_range(6))
         0:       base = ADDR_TEMP;
         1:       base = ADDR_PORT0;
         2:       base = ADDR_PORT1;
         3:       base = ADDR_PORT2;
         4:       base = ADDR_SENSOR;
         5:       base = ADDR_MOUSE_X;
         default: base = ADDR_MOUSE_Y;
      endcase
      // bit 0 is don't care on the bus
      return base | 12'($urandom_range(1));
   endfunction

   function automatic item_type random_item();
      item_type it;
      int       pick;
      it.write_data  = 16'($urandom);
      it.button_mask = 16'($urandom);
      it.pressed     = 1'($urandom);
      it.delta_x     = random_delta();
      it.delta_y     = random_delta();
      it.addr        = ($urandom_range(9) < 8) ? mapped_offset() : 12'($urandom);
      pick           = $urandom_range(99);
      if (pick < 35) begin
         it.mode = MODE_READ;
      end else if (pick < 45) begin
         it.mode = MODE_WRITE;
         if ($urandom_range(9) < 7) it.addr = ADDR_SENSOR | 12'($urandom_range(1));
      end else if (pick < 60) begin
         it.mode = MODE_PAD_BTN;
      end else if (pick < 72) begin
         it.mode = MODE_MOUSE_BTN;
      end else if (pick < 95) begin
         it.mode = MODE_MOTION;
      end else begin
         it.mode = 3'($urandom_range(7, MODE_FIRST_UNUSED));
      end
      return it;
   endfunction

   // register settings per phase: pad present, mouse present, anything
   task automatic random_config(input int phase);
      logic       pad_en;
      logic       mouse_en;
      logic       pad_plug;
      logic       mouse_plug;
      logic [9:0] temp;
      logic [6:0] sensors;
      pad_en     = 1'($urandom);
      mouse_en   = 1'($urandom);
      pad_plug   = 1'($urandom);
      mouse_plug = 1'($urandom);
      case (phase % 3)
         0: begin
            pad_en     = ($urandom_range(3) != 0);
            pad_plug   = 1'b1;
            mouse_plug = 1'b0;
         end
         1: begin
            mouse_en   = ($urandom_range(3) != 0);
            mouse_plug = 1'b1;
         end
         default: ;
      endcase
      case ($urandom_range(3))
         0:       temp = '0;
         1:       temp = '1;
         default: temp = 10'($urandom);
      endcase
      case ($urandom_range(3))
         0:       sensors = '0;
         1:       sensors = '1;
         default: sensors = 7'($urandom);
      endcase
      // junk in the upper bits must be dropped by the block
      csr_write(CSR_SCAN_PAD,   {31'($urandom), pad_en});
      csr_write(CSR_SCAN_MOUSE, {31'($urandom), mouse_en});
      csr_write(CSR_PAD_PLUG,   {31'($urandom), pad_plug});
      csr_write(CSR_MOUSE_PLUG, {31'($urandom), mouse_plug});
      csr_write(CSR_TEMP,       {22'($urandom), temp});
      csr_write(CSR_SENSOR,     {25'($urandom), sensors});
   endtask

   initial begin : stimulus
      item_type junk;
      // reset held from the start, released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: nothing plugged, scan off
      bus_read(ADDR_TEMP);
      bus_read(ADDR_PORT0);
      bus_write(ADDR_SENSOR | 12'h001, 16'hFFFF);    // odd offset still hits the latch
      bus_read(ADDR_SENSOR);
      button_event(MODE_PAD_BTN, 16'hFFFF, 1'b1);    // pad absent, ignored
      button_event(MODE_MOUSE_BTN, 16'hFFFF, 1'b1);  // mouse unplugged, ignored
      motion(13'sd4095, -13'sd4096);                 // counters stay zero
      for (int k = MODE_FIRST_UNUSED; k < 8; k++) begin
         // unknown kinds with random content change nothing
         junk      = random_item();
         junk.mode = 3'(k);
         send_beat(junk);
      end
      bus_read(12'hFFF);                             // unmapped read
      bus_write(12'h0FE, 16'h0100);                  // unmapped write

      // mouse plugged with counters on; pad plugged too but shadowed
      wait_idle();
      csr_write(CSR_SCAN_PAD, 32'h1);
      csr_write(CSR_SCAN_MOUSE, 32'h1);
      csr_write(CSR_PAD_PLUG, 32'h1);
      csr_write(CSR_MOUSE_PLUG, 32'h1);
      csr_write(CSR_TEMP, 32'hFFFF_FFFF);
      csr_write(CSR_SENSOR, 32'hFFFF_FFFF);
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
      motion(13'sd4095, 13'sd4095);                  // both saturate high
      motion(13'sd100, -13'sd4096);                  // y saturates low
      button_event(MODE_MOUSE_BTN, 16'h7000, 1'b1);
      bus_read(ADDR_MOUSE_X);                        // read clears x
      bus_read(ADDR_MOUSE_Y | 12'h001);
      button_event(MODE_MOUSE_BTN, 16'h8FFF, 1'b0);  // no bits in 12..14
      bus_read(ADDR_PORT2);
      button_event(MODE_PAD_BTN, 16'hFFFF, 1'b1);    // pad shadowed by the mouse
      motion(-13'sd5, 13'sd7);

      // pad present, mouse unplugged (counters cleared), extremes at zero
      wait_idle();
      csr_write(CSR_MOUSE_PLUG, 32'h0);
      csr_write(CSR_SCAN_MOUSE, 32'h0);
      csr_write(CSR_TEMP, 32'h0);
      csr_write(CSR_SENSOR, 32'h0);
      button_event(MODE_PAD_BTN, 16'hFFFF, 1'b1);
      button_event(MODE_PAD_BTN, 16'h0F0F, 1'b0);
      bus_read(ADDR_PORT0);
      bus_read(ADDR_PORT1);
      bus_read(ADDR_PORT2);
      bus_write(ADDR_SENSOR, 16'h0000);
      bus_read(ADDR_MOUSE_X);

      // random phases, one of them without any idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         random_config(phase);
         idling_on = (phase != 2);
         repeat (BEATS_PER_PHASE) send_beat(random_item());
      end
      idling_on = 1'b1;

      // drain, then wait on for any stray response
      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_controller_port_io_registers: clean");
      end else begin
         $display("tb_controller_port_io_registers: errors");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("tb_controller_port_io_registers: errors");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/cpio_pkg.sv
rtl/cpio_csr.sv
rtl/cpio_core.sv
rtl/controller_port_io_registers.sv
tb/sv/port_response_checker.sv
tb/sv/tb_controller_port_io_registers.sv
